### rtl/bsbs_pkg.sv
package bsbs_pkg;

   localparam int MAX_ENTRIES   = 10;
   localparam int FRACTION_BITS = 16;
   localparam int POSE_COUNT    = 10;

   localparam int WGT_W       = 24;
   localparam int IDX_W       = 4;
   localparam int POSE_W      = 4;
   localparam int FRAC_W      = 16;
   localparam int CNT_FIELD_W = 4;
   localparam int EPS_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int TAB_AW = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int DIV_W  = WGT_W + 1;
   localparam int FONE_W = FRACTION_BITS + 1;
   localparam int CMP_W  = ((FONE_W > EPS_W) ? FONE_W : EPS_W) + 1;

   localparam logic [FONE_W-1:0] FRAC_ONE = FONE_W'(1) << FRACTION_BITS;
   localparam logic [CMP_W-1:0]  FRAC_FIELD_MAX = CMP_W'((64'd1 << FRAC_W) - 64'd1);

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENTRY_COUNT = 2'd0,
      CSR_USE_WEIGHT  = 2'd1,
      CSR_SNAP_EPS    = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic              empty;
      logic              above;
      logic              done;
      logic              first;
      logic              last;
      logic [POSE_W-1:0] plo;
      logic [POSE_W-1:0] phi;
      logic [POSE_W-1:0] p0;
      logic [POSE_W-1:0] pn;
   } ctl_type;

endpackage

### rtl/bsbs_div.sv
module bsbs_div (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_vld,
   input  bsbs_pkg::ctl_type                       in_ctl,
   input  logic signed [bsbs_pkg::DIV_W-1:0]       in_num,
   input  logic signed [bsbs_pkg::DIV_W-1:0]       in_den,
   output logic                                    out_vld,
   output bsbs_pkg::ctl_type                       out_ctl,
   output logic [bsbs_pkg::FRACTION_BITS-1:0]      out_quo,
   output logic                                    out_one,
   output logic                                    out_zero
);
   import bsbs_pkg::*;

   localparam int LAST = FRACTION_BITS + 1;

   logic                     vld_ff  [0:LAST];
   ctl_type                  ctl_ff  [0:LAST];
   logic [DIV_W-1:0]         rem_ff  [0:LAST];
   logic [DIV_W-1:0]         den_ff  [0:LAST];
   logic [FRACTION_BITS-1:0] quo_ff  [0:LAST];
   logic                     one_ff  [0:LAST];
   logic                     zero_ff [0:LAST];

   logic                     vld_in  [0:LAST];
   ctl_type                  ctl_in  [0:LAST];
   logic [DIV_W-1:0]         rem_in  [0:LAST];
   logic [DIV_W-1:0]         den_in  [0:LAST];
   logic [FRACTION_BITS-1:0] quo_in  [0:LAST];
   logic                     one_in  [0:LAST];
   logic                     zero_in [0:LAST];

   logic             num_pos;
   logic [DIV_W:0]   shl  [0:LAST];
   logic             ge   [0:LAST];

   always_comb begin
      // classify signs, take magnitudes
      num_pos   = !in_num[DIV_W-1] && (in_num != '0);
      vld_in[0] = in_vld;
      ctl_in[0] = in_ctl;
      quo_in[0] = '0;
      rem_in[0] = in_num[DIV_W-1] ? DIV_W'(-in_num) : DIV_W'(in_num);
      den_in[0] = in_den[DIV_W-1] ? DIV_W'(-in_den) : DIV_W'(in_den);
      if (in_den == '0) begin
         one_in[0]  = num_pos;
         zero_in[0] = !num_pos;
      end else begin
         one_in[0]  = 1'b0;
         zero_in[0] = (in_num == '0) || (in_num[DIV_W-1] != in_den[DIV_W-1]);
      end

      // saturate when the quotient reaches one
      vld_in[1]  = vld_ff[0];
      ctl_in[1]  = ctl_ff[0];
      rem_in[1]  = rem_ff[0];
      den_in[1]  = den_ff[0];
      quo_in[1]  = quo_ff[0];
      zero_in[1] = zero_ff[0];
      one_in[1]  = one_ff[0] || (!zero_ff[0] && (rem_ff[0] >= den_ff[0]));

      // one quotient bit per stage
      shl[0] = '0;
      ge[0]  = 1'b0;
      shl[1] = '0;
      ge[1]  = 1'b0;
      for (int j = 2; j <= LAST; j++) begin
         shl[j]     = {rem_ff[j-1], 1'b0};
         ge[j]      = shl[j] >= {1'b0, den_ff[j-1]};
         vld_in[j]  = vld_ff[j-1];
         ctl_in[j]  = ctl_ff[j-1];
         den_in[j]  = den_ff[j-1];
         one_in[j]  = one_ff[j-1];
         zero_in[j] = zero_ff[j-1];
         rem_in[j]  = ge[j] ? DIV_W'(shl[j] - {1'b0, den_ff[j-1]}) : DIV_W'(shl[j]);
         quo_in[j]  = {quo_ff[j-1][FRACTION_BITS-2:0], ge[j]};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= LAST; j++) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_in[j];
         end
         ctl_ff[j]  <= ctl_in[j];
         rem_ff[j]  <= rem_in[j];
         den_ff[j]  <= den_in[j];
         quo_ff[j]  <= quo_in[j];
         one_ff[j]  <= one_in[j];
         zero_ff[j] <= zero_in[j];
      end
   end

   assign out_vld  = vld_ff[LAST];
   assign out_ctl  = ctl_ff[LAST];
   assign out_quo  = quo_ff[LAST];
   assign out_one  = one_ff[LAST];
   assign out_zero = zero_ff[LAST];

endmodule

### rtl/breakpoint_segment_blend_select_top.sv
// channel   ports                                     handshake
// request   req_cmd, req_entry_*, req_blend_weight    start & !busy
// response  rsp_found, rsp_pose_*, rsp_fraction       rsp_valid, one cycle
// config    csr_index, csr_wdata                      csr_we
//
// One item enters per cycle; busy stays low. A lookup's result is registered
// through stages A, B and C, the divider and the response register; the
// divider resolves one quotient bit per stage. A write item updates
// the table at its accepting edge and gives no result.
// Reset is synchronous: it clears the valid bits and the configuration
// registers; table entries hold nothing defined until written. Nothing stalls.
module breakpoint_segment_blend_select_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_cmd,
   input  logic [bsbs_pkg::IDX_W-1:0]             req_entry_index,
   input  logic signed [bsbs_pkg::WGT_W-1:0]      req_entry_threshold,
   input  logic [bsbs_pkg::POSE_W-1:0]            req_entry_pose,
   input  logic signed [bsbs_pkg::WGT_W-1:0]      req_blend_weight,
   output logic                                   rsp_valid,
   output logic                                   rsp_found,
   output logic [bsbs_pkg::POSE_W-1:0]            rsp_pose_low,
   output logic [bsbs_pkg::POSE_W-1:0]            rsp_pose_high,
   output logic [bsbs_pkg::FRAC_W-1:0]            rsp_fraction,
   input  logic                                   csr_we,
   input  logic [bsbs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bsbs_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import bsbs_pkg::*;

   logic accept;

   logic [CNT_FIELD_W-1:0] entry_count_ff;
   logic                   use_weight_ff;
   logic [EPS_W-1:0]       snap_eps_ff;

   logic signed [WGT_W-1:0] thr_ff  [MAX_ENTRIES];
   logic [POSE_W-1:0]       pose_ff [MAX_ENTRIES];

   logic                    a_vld_ff;
   logic signed [WGT_W-1:0] a_wgt_ff;

   logic [CNT_W-1:0]        n_eff;
   logic signed [WGT_W-1:0] w_sel;
   logic [MAX_ENTRIES-1:0]  le;
   logic [MAX_ENTRIES-1:0]  cand;
   logic [MAX_ENTRIES-1:0]  hit;
   logic [MAX_ENTRIES-1:0]  hit_dn;
   ctl_type                 b_ctl_in;
   logic signed [WGT_W-1:0] b_tlo_in;
   logic signed [WGT_W-1:0] b_thi_in;

   logic                    b_vld_ff;
   ctl_type                 b_ctl_ff;
   logic signed [WGT_W-1:0] b_w_ff;
   logic signed [WGT_W-1:0] b_tlo_ff;
   logic signed [WGT_W-1:0] b_thi_ff;

   logic                    c_vld_ff;
   ctl_type                 c_ctl_ff;
   logic signed [DIV_W-1:0] c_num_ff;
   logic signed [DIV_W-1:0] c_den_ff;

   logic                     d_vld;
   ctl_type                  d_ctl;
   logic [FRACTION_BITS-1:0] d_quo;
   logic                     d_one;
   logic                     d_zero;

   logic [FONE_W-1:0] f_val;
   logic [CMP_W-1:0]  f_sum;
   logic              snap_hi;
   logic              snap_lo;
   logic [POSE_W-1:0] lo_in;
   logic [POSE_W-1:0] hi_in;
   logic [FONE_W-1:0] f_in;
   logic              found_in;
   logic [FRAC_W-1:0] frac_in;

   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [POSE_W-1:0] rsp_pose_low_ff;
   logic [POSE_W-1:0] rsp_pose_high_ff;
   logic [FRAC_W-1:0] rsp_fraction_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         use_weight_ff  <= 1'b1;
         snap_eps_ff    <= EPS_W'(1);
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata[CNT_FIELD_W-1:0];
            CSR_USE_WEIGHT:  use_weight_ff  <= csr_wdata[0];
            CSR_SNAP_EPS:    snap_eps_ff    <= csr_wdata[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_cmd == CMD_WRITE) && (int'(req_entry_index) < MAX_ENTRIES)) begin
         thr_ff[TAB_AW'(req_entry_index)]  <= req_entry_threshold;
         pose_ff[TAB_AW'(req_entry_index)] <= req_entry_pose;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept && (req_cmd == CMD_LOOKUP);
      end
      a_wgt_ff <= req_blend_weight;
   end

   // compare against every breakpoint, pick the first of entries 1 to n_eff-1 at or above the weight
   assign n_eff = (int'(entry_count_ff) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                       : CNT_W'(entry_count_ff);
   assign w_sel = use_weight_ff ? a_wgt_ff : thr_ff[0];

   always_comb begin
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         le[k]   = w_sel <= thr_ff[k];
         cand[k] = (k >= 1) && (k < int'(n_eff)) && le[k];
      end
      hit    = cand & (~cand + MAX_ENTRIES'(1));
      hit_dn = hit >> 1;

      b_ctl_in       = '0;
      b_tlo_in       = '0;
      b_thi_in       = '0;
      b_ctl_in.empty = (n_eff == '0);
      b_ctl_in.above = !le[0];
      b_ctl_in.done  = |hit;
      b_ctl_in.first = hit[1];
      b_ctl_in.p0    = pose_ff[0];
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         b_thi_in     = b_thi_in | (hit[k] ? thr_ff[k] : '0);
         b_ctl_in.phi = b_ctl_in.phi | (hit[k] ? pose_ff[k] : '0);
         b_tlo_in     = b_tlo_in | (hit_dn[k] ? thr_ff[k] : '0);
         b_ctl_in.plo = b_ctl_in.plo | (hit_dn[k] ? pose_ff[k] : '0);
         b_ctl_in.pn  = b_ctl_in.pn | ((k == int'(n_eff) - 1) ? pose_ff[k] : '0);
         b_ctl_in.last = b_ctl_in.last | (hit[k] && (k == int'(n_eff) - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
      b_ctl_ff <= b_ctl_in;
      b_w_ff   <= w_sel;
      b_tlo_ff <= b_tlo_in;
      b_thi_ff <= b_thi_in;
      c_ctl_ff <= b_ctl_ff;
      c_num_ff <= DIV_W'(b_w_ff) - DIV_W'(b_tlo_ff);
      c_den_ff <= DIV_W'(b_thi_ff) - DIV_W'(b_tlo_ff);
   end

   bsbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (c_vld_ff),
      .in_ctl   (c_ctl_ff),
      .in_num   (c_num_ff),
      .in_den   (c_den_ff),
      .out_vld  (d_vld),
      .out_ctl  (d_ctl),
      .out_quo  (d_quo),
      .out_one  (d_one),
      .out_zero (d_zero)
   );

   // snap near the ends of the segment, clamp out-of-range weights to the end poses, clear an empty table's result
   always_comb begin
      f_val   = d_one ? FRAC_ONE : (d_zero ? '0 : {1'b0, d_quo});
      f_sum   = CMP_W'(f_val) + CMP_W'(snap_eps_ff);
      snap_hi = f_sum > CMP_W'(FRAC_ONE);
      snap_lo = CMP_W'(f_val) < CMP_W'(snap_eps_ff);

      lo_in = d_ctl.plo;
      hi_in = d_ctl.phi;
      f_in  = f_val;
      if (!d_ctl.above) begin
         lo_in = d_ctl.p0;
         hi_in = d_ctl.p0;
         f_in  = '0;
      end else if (!d_ctl.done) begin
         lo_in = d_ctl.pn;
         hi_in = d_ctl.pn;
         f_in  = '0;
      end else if (d_ctl.first && snap_lo) begin
         lo_in = d_ctl.p0;
         hi_in = d_ctl.p0;
         f_in  = '0;
      end else if (d_ctl.last && snap_hi) begin
         lo_in = d_ctl.pn;
         hi_in = d_ctl.pn;
         f_in  = '0;
      end else if (snap_hi) begin
         lo_in = d_ctl.phi;
         f_in  = '0;
      end

      found_in = (int'(lo_in) < POSE_COUNT) && (int'(hi_in) < POSE_COUNT);
      frac_in  = (CMP_W'(f_in) > FRAC_FIELD_MAX) ? FRAC_W'(FRAC_FIELD_MAX) : FRAC_W'(f_in);

      if (d_ctl.empty) begin
         found_in = 1'b0;
         lo_in    = '0;
         hi_in    = '0;
         frac_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d_vld;
      end
      rsp_found_ff     <= found_in;
      rsp_pose_low_ff  <= lo_in;
      rsp_pose_high_ff <= hi_in;
      rsp_fraction_ff  <= frac_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_pose_low  = rsp_pose_low_ff;
   assign rsp_pose_high = rsp_pose_high_ff;
   assign rsp_fraction  = rsp_fraction_ff;

endmodule

### test/breakpoint_segment_blend_select_top_test.sv
module breakpoint_segment_blend_select_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bsbs_pkg::*;

   localparam int LATENCY = FRACTION_BITS + 5;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 900;
   localparam longint WGT_MAX = (longint'(1) <<< (WGT_W - 1)) - 1;
   localparam longint WGT_MIN = -(longint'(1) <<< (WGT_W - 1));

   typedef struct {
      cmd_type                  cmd;
      logic [IDX_W-1:0]         index;
      logic signed [WGT_W-1:0]  threshold;
      logic [POSE_W-1:0]        pose;
      logic signed [WGT_W-1:0]  weight;
   } bp_item_type;

   typedef struct {
      logic                found;
      logic [POSE_W-1:0]   pose_low;
      logic [POSE_W-1:0]   pose_high;
      logic [FRAC_W-1:0]   fraction;
   } blend_type;

   typedef struct {
      bit                      is_csr;
      csr_idx_type             reg_sel;
      logic [CSR_DATA_W-1:0]   reg_val;
      bp_item_type             item;
      bit                      typed;
      blend_type               want;
   } step_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_cmd = 1'b0;
   logic [IDX_W-1:0]             req_entry_index = '0;
   logic signed [WGT_W-1:0]      req_entry_threshold = '0;
   logic [POSE_W-1:0]            req_entry_pose = '0;
   logic signed [WGT_W-1:0]      req_blend_weight = '0;
   logic                         rsp_valid;
   logic                         rsp_found;
   logic [POSE_W-1:0]            rsp_pose_low;
   logic [POSE_W-1:0]            rsp_pose_high;
   logic [FRAC_W-1:0]            rsp_fraction;
   logic                         csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   logic signed [WGT_W-1:0]  thr_mem [MAX_ENTRIES];
   logic [POSE_W-1:0]        pose_mem [MAX_ENTRIES];
   logic [CNT_FIELD_W-1:0]   cfg_count = '0;
   logic                     cfg_use = 1'b1;
   logic [EPS_W-1:0]         cfg_eps = 16'd1;

   blend_type  pending_blends [$];
   blend_type  oldest;
   step_type   script [$];
   int      fails = 0;
   int      cycles = 0;
   int      burst_left = 0;

   breakpoint_segment_blend_select_top u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic blend_type lookup_blend(logic signed [WGT_W-1:0] in_weight);
      longint n, w, f, eps, num, den, an, ad, q, one;
      int i;
      bit done;
      logic [POSE_W-1:0] lo, hi;
      blend_type r;
      one = longint'(1) << FRACTION_BITS;
      n = (cfg_count > MAX_ENTRIES) ? MAX_ENTRIES : cfg_count;
      f = 0;
      done = 1'b0;
      r.found = 1'b0;
      r.pose_low = '0;
      r.pose_high = '0;
      r.fraction = '0;
      if (n == 0) return r;
      w = cfg_use ? longint'(in_weight) : longint'(thr_mem[0]);
      eps = longint'(cfg_eps);
      lo = pose_mem[0];
      hi = lo;
      if (w > longint'(thr_mem[0])) begin
         for (i = 1; i < n && !done; i++) begin
            if (w <= longint'(thr_mem[i])) begin
               done = 1'b1;
               num = w - longint'(thr_mem[i-1]);
               den = longint'(thr_mem[i]) - longint'(thr_mem[i-1]);
               if (den == 0) begin
                  f = (num > 0) ? one : 0;
               end else if (num == 0 || ((num > 0) != (den > 0))) begin
                  f = 0;
               end else begin
                  an = (num > 0) ? num : -num;
                  ad = (den > 0) ? den : -den;
                  q = (an << FRACTION_BITS) / ad;
                  f = (q > one) ? one : q;
               end
               lo = pose_mem[i-1];
               hi = pose_mem[i];
               if (i == 1 && f < eps) begin
                  lo = pose_mem[0];
                  hi = lo;
                  f = 0;
               end else if (i == n - 1 && f > one - eps) begin
                  lo = pose_mem[n-1];
                  hi = lo;
                  f = 0;
               end else if (f > one - eps) begin
                  lo = hi;
                  f = 0;
               end
            end
         end
         if (!done) begin
            lo = pose_mem[n-1];
            hi = lo;
            f = 0;
         end
      end
      r.found = (lo < POSE_COUNT) && (hi < POSE_COUNT);
      r.pose_low = lo;
      r.pose_high = hi;
      r.fraction = (f > 65535) ? 16'hFFFF : FRAC_W'(f);
      return r;
   endfunction

   function automatic logic signed [WGT_W-1:0] clamp_weight(longint v);
      if (v > WGT_MAX) v = WGT_MAX;
      else if (v < WGT_MIN) v = WGT_MIN;
      return v[WGT_W-1:0];
   endfunction

   function automatic step_type blank_step();
      step_type s;
      s.is_csr = 1'b0;
      s.reg_sel = CSR_ENTRY_COUNT;
      s.reg_val = '0;
      s.item.cmd = CMD_WRITE;
      s.item.index = '0;
      s.item.threshold = '0;
      s.item.pose = '0;
      s.item.weight = '0;
      s.typed = 1'b0;
      s.want = '{default: '0};
      return s;
   endfunction

   function automatic step_type csr_step(csr_idx_type sel, logic [CSR_DATA_W-1:0] val);
      step_type s;
      s = blank_step();
      s.is_csr = 1'b1;
      s.reg_sel = sel;
      s.reg_val = val;
      return s;
   endfunction

   function automatic step_type write_step(logic [IDX_W-1:0] idx,
                                           logic signed [WGT_W-1:0] thr,
                                           logic [POSE_W-1:0] pose);
      step_type s;
      s = blank_step();
      s.item.cmd = CMD_WRITE;
      s.item.index = idx;
      s.item.threshold = thr;
      s.item.pose = pose;
      return s;
   endfunction

   function automatic step_type lookup_step(logic signed [WGT_W-1:0] wgt);
      step_type s;
      s = blank_step();
      s.item.cmd = CMD_LOOKUP;
      s.item.weight = wgt;
      return s;
   endfunction

   function automatic step_type expect_step(logic signed [WGT_W-1:0] wgt, logic found,
                                            logic [POSE_W-1:0] lo, logic [POSE_W-1:0] hi,
                                            logic [FRAC_W-1:0] frac);
      step_type s;
      s = lookup_step(wgt);
      s.typed = 1'b1;
      s.want.found = found;
      s.want.pose_low = lo;
      s.want.pose_high = hi;
      s.want.fraction = frac;
      return s;
   endfunction

   task automatic issue(bp_item_type it, bit typed, blend_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      start <= 1'b1;
      req_cmd <= it.cmd;
      req_entry_index <= it.index;
      req_entry_threshold <= it.threshold;
      req_entry_pose <= it.pose;
      req_blend_weight <= it.weight;
      do @(posedge clock); while (busy !== 1'b0);
      if (it.cmd == CMD_LOOKUP) begin
         pending_blends.push_back(typed ? want : lookup_blend(it.weight));
      end else if (it.index < MAX_ENTRIES) begin
         thr_mem[it.index] = it.threshold;
         pose_mem[it.index] = it.pose;
      end
   endtask

   task automatic quiesce();
      start <= 1'b0;
      while (pending_blends.size() != 0) @(posedge clock);
      repeat (LATENCY + 3) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type sel, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(posedge clock);
      case (sel)
         CSR_ENTRY_COUNT: cfg_count = val[CNT_FIELD_W-1:0];
         CSR_USE_WEIGHT:  cfg_use = val[0];
         CSR_SNAP_EPS:    cfg_eps = val[EPS_W-1:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_blends.size() == 0) begin
            $error("result with no lookup pending");
            fails++;
         end else begin
            oldest = pending_blends.pop_front();
            if (rsp_found !== oldest.found) begin
               $error("found: expected %0d, got %0d", oldest.found, rsp_found);
               fails++;
            end
            if (rsp_pose_low !== oldest.pose_low) begin
               $error("pose_low: expected %0d, got %0d", oldest.pose_low, rsp_pose_low);
               fails++;
            end
            if (rsp_pose_high !== oldest.pose_high) begin
               $error("pose_high: expected %0d, got %0d", oldest.pose_high, rsp_pose_high);
               fails++;
            end
            if (rsp_fraction !== oldest.fraction) begin
               $error("fraction: expected %0d, got %0d", oldest.fraction, rsp_fraction);
               fails++;
            end
         end
      end
   end

   initial begin
      int sent, k, phase_len;
      longint scale, cur, a, b, w;
      logic [CNT_FIELD_W-1:0] count_val;
      logic [EPS_W-1:0] eps_val;
      bp_item_type it;
      blend_type none;

      none = '{default: '0};

      script.push_back(expect_step(24'sh7FFFFF, 1'b0, 4'd0, 4'd0, 16'd0));
      script.push_back(write_step(4'd0, 24'sh800000, 4'd0));
      script.push_back(write_step(4'd1, 24'shFE0000, 4'd1));
      script.push_back(write_step(4'd2, 24'sh000000, 4'd2));
      script.push_back(write_step(4'd3, 24'sh010000, 4'd3));
      script.push_back(write_step(4'd4, 24'sh020000, 4'd4));
      script.push_back(write_step(4'd5, 24'sh030000, 4'd5));
      script.push_back(write_step(4'd6, 24'sd300000, 4'd6));
      script.push_back(write_step(4'd7, 24'sd1000000, 4'd7));
      script.push_back(write_step(4'd8, 24'sd4000000, 4'd8));
      script.push_back(write_step(4'd9, 24'sh7FFFFF, 4'd9));
      script.push_back(write_step(4'd15, 24'sd1234, 4'd15));
      script.push_back(csr_step(CSR_ENTRY_COUNT, 16'd10));
      script.push_back(expect_step(24'sh800000, 1'b1, 4'd0, 4'd0, 16'd0));
      script.push_back(expect_step(24'sh7FFFFF, 1'b1, 4'd9, 4'd9, 16'd0));
      script.push_back(lookup_step(24'shFE0001));
      script.push_back(lookup_step(24'sh800001));
      script.push_back(lookup_step(24'sh008000));
      script.push_back(lookup_step(24'sh000000));
      script.push_back(csr_step(CSR_SNAP_EPS, 16'd0));
      script.push_back(expect_step(24'sh020000, 1'b1, 4'd3, 4'd4, 16'hFFFF));
      script.push_back(csr_step(CSR_SNAP_EPS, 16'hFFFF));
      script.push_back(lookup_step(24'sd100000));
      script.push_back(csr_step(CSR_USE_WEIGHT, 16'd0));
      script.push_back(expect_step(24'sh7FFFFF, 1'b1, 4'd0, 4'd0, 16'd0));
      script.push_back(write_step(4'd3, 24'sh010000, 4'd15));
      script.push_back(csr_step(CSR_USE_WEIGHT, 16'd1));
      script.push_back(csr_step(CSR_SNAP_EPS, 16'd1));
      script.push_back(lookup_step(24'sh008000));
      script.push_back(write_step(4'd3, 24'sh010000, 4'd3));
      script.push_back(csr_step(CSR_ENTRY_COUNT, 16'd15));
      script.push_back(lookup_step(24'sd5000000));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            quiesce();
            write_csr(script[i].reg_sel, script[i].reg_val);
            csr_we <= 1'b0;
         end else begin
            issue(script[i].item, script[i].typed, script[i].want);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: count_val = CNT_FIELD_W'(0);
            1: count_val = CNT_FIELD_W'(1);
            2: count_val = CNT_FIELD_W'(15);
            3, 4: count_val = CNT_FIELD_W'(MAX_ENTRIES);
            default: count_val = CNT_FIELD_W'($urandom_range(2, MAX_ENTRIES));
         endcase
         case ($urandom_range(0, 7))
            0: eps_val = 16'd0;
            1: eps_val = 16'hFFFF;
            2: eps_val = 16'd1;
            3: eps_val = EPS_W'($urandom);
            default: eps_val = EPS_W'($urandom_range(0, 2048));
         endcase
         quiesce();
         write_csr(CSR_ENTRY_COUNT, CSR_DATA_W'(count_val));
         write_csr(CSR_USE_WEIGHT, CSR_DATA_W'($urandom_range(0, 4) != 0));
         write_csr(CSR_SNAP_EPS, CSR_DATA_W'(eps_val));
         csr_we <= 1'b0;

         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 2))
               0: scale = 16;
               1: scale = 70000;
               default: scale = 1600000;
            endcase
            cur = longint'($urandom_range(0, 24'hFFFFFF)) + WGT_MIN;
            if (cur > WGT_MAX - 10 * scale) cur = WGT_MAX - 10 * scale;
            if (cur < WGT_MIN) cur = WGT_MIN;
            for (k = 0; k < MAX_ENTRIES; k++) begin
               it.cmd = CMD_WRITE;
               it.index = IDX_W'(k);
               it.weight = WGT_W'($urandom);
               it.pose = ($urandom_range(0, 9) == 0) ? POSE_W'($urandom_range(10, 15))
                                                     : POSE_W'($urandom_range(0, 9));
               if ($urandom_range(0, 4) == 0) it.threshold = WGT_W'($urandom);
               else it.threshold = clamp_weight(cur);
               cur += longint'($urandom_range(0, 32'(scale)));
               issue(it, 1'b0, none);
               sent++;
            end
         end

         phase_len = $urandom_range(30, 90);
         repeat (phase_len) begin
            it.index = IDX_W'($urandom);
            it.threshold = WGT_W'($urandom);
            it.pose = POSE_W'($urandom);
            it.weight = WGT_W'($urandom);
            if ($urandom_range(0, 9) < 8) begin
               it.cmd = CMD_LOOKUP;
               case ($urandom_range(0, 5))
                  0: ;
                  1, 2: begin
                     k = $urandom_range(0, MAX_ENTRIES - 1);
                     w = longint'(thr_mem[k]) + longint'($urandom_range(0, 6)) - 3;
                     it.weight = clamp_weight(w);
                  end
                  default: begin
                     k = $urandom_range(0, MAX_ENTRIES - 2);
                     a = longint'(thr_mem[k]);
                     b = longint'(thr_mem[k+1]);
                     if (b > a) w = a + longint'($urandom_range(0, 32'(b - a)));
                     else w = a;
                     it.weight = clamp_weight(w);
                  end
               endcase
            end else begin
               it.cmd = CMD_WRITE;
               if ($urandom_range(0, 9) != 0) it.pose = POSE_W'($urandom_range(0, 9));
            end
            issue(it, 1'b0, none);
            sent++;
            if ($urandom_range(0, 49) == 0) quiesce();
         end
      end

      quiesce();
      if (fails == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/bsbs_pkg.sv
rtl/bsbs_div.sv
rtl/breakpoint_segment_blend_select_top.sv
test/breakpoint_segment_blend_select_top_test.sv
